[src/pmmu_pkg.sv]
// pmmu_pkg: shared types, codes and address constants of the paged memory map unit.
// No dependencies; imported by pmmu_decode and paged_memory_map_unit_top.
`default_nettype none

package pmmu_pkg;

  localparam int PAGE_COUNT_DEF  = 8;
  localparam int FRAME_COUNT_DEF = 64;
  localparam int PAGE_BYTES_DEF  = 8192;
  localparam int STACK_DEPTH_DEF = 4;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_PUSH  = 2'd3;

  localparam logic [3:0] T_RAM      = 4'd0;
  localparam logic [3:0] T_ROM      = 4'd1;
  localparam logic [3:0] T_KBD      = 4'd2;
  localparam logic [3:0] T_USB_RD   = 4'd3;
  localparam logic [3:0] T_PTE      = 4'd4;
  localparam logic [3:0] T_UART     = 4'd5;
  localparam logic [3:0] T_USB_WR   = 4'd6;
  localparam logic [3:0] T_USB_CMD  = 4'd7;
  localparam logic [3:0] T_INTERNAL = 4'd8;
  localparam logic [3:0] T_NONE     = 4'd9;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_INVALID = 3'd1;
  localparam logic [2:0] E_ROMWR   = 3'd2;
  localparam logic [2:0] E_UNKNOWN = 3'd3;
  localparam logic [2:0] E_OVER    = 3'd4;
  localparam logic [2:0] E_UNDER   = 3'd5;

  localparam logic [15:0] A_TOP      = 16'hff00;
  localparam logic [15:0] A_IO       = 16'hfe00;
  localparam logic [15:0] A_UROM     = 16'h8000;
  localparam logic [15:0] A_ROM_MASK = 16'h7fff;
  localparam logic [15:0] A_PTE      = 16'hfe70;
  localparam logic [15:0] A_USER     = 16'hfe60;
  localparam logic [15:0] A_POP      = 16'hfe80;
  localparam logic [15:0] A_ROM_OFF  = 16'hfe50;
  localparam logic [15:0] A_ROM_ON   = 16'hfe51;
  localparam logic [15:0] A_KBD      = 16'hfe10;
  localparam logic [15:0] A_USB_RD   = 16'hfe30;
  localparam logic [15:0] A_UART     = 16'hfe20;
  localparam logic [15:0] A_USB_WR   = 16'hfe40;
  localparam logic [15:0] A_USB_CMD  = 16'hfe41;

  localparam logic [7:0] PTE_INVALID = 8'h80;

  typedef struct packed {
    logic [3:0]  target;
    logic [18:0] phys;
    logic [7:0]  rd;
    logic [7:0]  dout;
    logic [2:0]  err;
    logic        io_vis;
    logic        rom_vis;
  } result_t;

endpackage

`default_nettype wire

[src/pmmu_decode.sv]
// pmmu_decode: combinational address decode, translation and next-state for one beat.
// Depends on pmmu_pkg.
`default_nettype none

module pmmu_decode #(
  parameter int PAGE_COUNT  = pmmu_pkg::PAGE_COUNT_DEF,
  parameter int FRAME_COUNT = pmmu_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BYTES  = pmmu_pkg::PAGE_BYTES_DEF,
  parameter int STACK_DEPTH = pmmu_pkg::STACK_DEPTH_DEF
) (
  input  logic [1:0]                       op,
  input  logic [15:0]                      addr,
  input  logic [7:0]                       data,
  input  logic [$clog2(STACK_DEPTH)-1:0]   level,
  input  logic [STACK_DEPTH-1:0]           io_stk,
  input  logic [STACK_DEPTH-1:0]           rom_stk,
  input  logic [7:0]                       pte [PAGE_COUNT],
  output pmmu_pkg::result_t                res,
  output logic [$clog2(STACK_DEPTH)-1:0]   level_next,
  output logic [STACK_DEPTH-1:0]           io_next,
  output logic [STACK_DEPTH-1:0]           rom_next,
  output logic [7:0]                       pte_next [PAGE_COUNT]
);
  import pmmu_pkg::*;

  localparam int LW     = $clog2(STACK_DEPTH);
  localparam int PIW    = $clog2(PAGE_COUNT);
  localparam int FIW    = $clog2(FRAME_COUNT);
  localparam int OFW    = $clog2(PAGE_BYTES);
  localparam int PG_NUM = 65536 / PAGE_BYTES;

  logic [PIW-1:0] page_tab  [PG_NUM];
  logic [FIW-1:0] frame_tab [256];

  for (genvar g = 0; g < PG_NUM; g++) begin : g_page_tab
    assign page_tab[g] = PIW'(g % PAGE_COUNT);
  end

  for (genvar g = 0; g < 256; g++) begin : g_frame_tab
    assign frame_tab[g] = FIW'(g % FRAME_COUNT);
  end

  logic [15:0]        pte_diff;
  logic               pte_hit;
  logic [PIW-1:0]     pte_idx;
  logic [PIW-1:0]     sel_idx;
  logic [7:0]         entry;
  logic [FIW+OFW-1:0] ram_full;
  logic [18:0]        ram_phys;
  logic [18:0]        rom_phys;
  logic               io_cur;
  logic               rom_cur;
  logic [LW-1:0]      lv_up;
  logic [LW-1:0]      lv_dn;

  assign pte_diff = addr - A_PTE;
  assign pte_hit  = (addr >= A_PTE) && (pte_diff < 16'(PAGE_COUNT));
  assign pte_idx  = pte_diff[PIW-1:0];
  assign io_cur   = io_stk[level];
  assign rom_cur  = rom_stk[level];
  // one table read port: window index on I/O hits, page index otherwise
  assign sel_idx  = (pte_hit && io_cur) ? pte_idx : page_tab[addr[15:OFW]];
  assign entry    = pte[sel_idx];
  assign ram_full = {frame_tab[entry], addr[OFW-1:0]};
  assign ram_phys = 19'(ram_full);
  assign rom_phys = 19'(addr & A_ROM_MASK);
  assign lv_up    = LW'(level + 1'b1);
  assign lv_dn    = LW'(level - 1'b1);

  always_comb begin
    res        = '0;
    res.target = T_NONE;
    res.err    = E_NONE;
    level_next = level;
    io_next    = io_stk;
    rom_next   = rom_stk;
    pte_next   = pte;
    case (op)
      OP_PUSH: begin
        if (level == LW'(STACK_DEPTH - 1)) begin
          res.err = E_OVER;
        end else begin
          level_next      = lv_up;
          io_next[lv_up]  = 1'b1;
          rom_next[lv_up] = 1'b0;
          res.target      = T_INTERNAL;
        end
      end
      OP_LOAD: begin
        res.dout = data;
        if (addr >= A_UROM) begin
          res.target = T_ROM;
          res.phys   = rom_phys;
        end else begin
          res.target = T_RAM;
          res.phys   = ram_phys;
        end
      end
      default: begin
        if (addr >= A_TOP) begin
          if (op == OP_READ) begin
            res.target = T_ROM;
            res.phys   = rom_phys;
          end else begin
            res.err = E_ROMWR;
          end
        end else if (io_cur && addr >= A_IO) begin
          if (op == OP_READ) begin
            if (addr == A_KBD) begin
              res.target = T_KBD;
            end else if (addr == A_USB_RD) begin
              res.target = T_USB_RD;
            end else if (pte_hit) begin
              res.target = T_PTE;
              res.rd     = entry;
            end else begin
              res.err = E_UNKNOWN;
            end
          end else begin
            res.target = T_INTERNAL;
            if (addr == A_UART) begin
              res.target = T_UART;
              res.dout   = data;
            end else if (addr == A_USB_WR) begin
              res.target = T_USB_WR;
              res.dout   = data;
            end else if (addr == A_USB_CMD) begin
              res.target = T_USB_CMD;
              res.dout   = data;
            end else if (addr == A_ROM_OFF) begin
              rom_next[level] = 1'b0;
            end else if (addr == A_ROM_ON) begin
              rom_next[level] = 1'b1;
            end else if (addr == A_USER) begin
              level_next  = '0;
              io_next[0]  = 1'b0;
              rom_next[0] = 1'b0;
            end else if (pte_hit) begin
              pte_next[pte_idx] = data;
            end else if (addr == A_POP) begin
              if (level == '0) begin
                res.target = T_NONE;
                res.err    = E_UNDER;
              end else begin
                level_next = lv_dn;
              end
            end else begin
              res.target = T_NONE;
              res.err    = E_UNKNOWN;
            end
          end
        end else if (rom_cur && addr >= A_UROM) begin
          if (op == OP_READ) begin
            res.target = T_ROM;
            res.phys   = rom_phys;
          end else begin
            res.err = E_ROMWR;
          end
        end else begin
          res.target = T_RAM;
          res.phys   = ram_phys;
          if (op == OP_WRITE) begin
            res.dout = data;
          end
          if ((entry & PTE_INVALID) != 8'd0) begin
            res.err = E_INVALID;
          end
        end
      end
    endcase
    res.io_vis  = io_next[level_next];
    res.rom_vis = rom_next[level_next];
  end

endmodule

`default_nettype wire

[src/paged_memory_map_unit_top.sv]
// Paged memory map unit: takes one bus beat per cycle and returns its result beat in the
// cycle after acceptance; throughput is one beat per clock while the output is drained.
// Translation, page-table and stack updates are done in a single decode stage
// (pmmu_decode) in front of the result register. Depends on pmmu_pkg, pmmu_decode.
`default_nettype none

module paged_memory_map_unit_top #(
  parameter int PAGE_COUNT  = pmmu_pkg::PAGE_COUNT_DEF,
  parameter int FRAME_COUNT = pmmu_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BYTES  = pmmu_pkg::PAGE_BYTES_DEF,
  parameter int STACK_DEPTH = pmmu_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  target,
  output logic [18:0] physical_address,
  output logic [7:0]  read_byte,
  output logic [7:0]  data_out,
  output logic [2:0]  error_code,
  output logic        io_visible,
  output logic        rom_visible
);
  import pmmu_pkg::*;

  localparam int LW = $clog2(STACK_DEPTH);

  logic [7:0]             pte       [PAGE_COUNT];
  logic [7:0]             pte_next  [PAGE_COUNT];
  logic [LW-1:0]          level;
  logic [LW-1:0]          level_next;
  logic [STACK_DEPTH-1:0] io_stk;
  logic [STACK_DEPTH-1:0] io_next;
  logic [STACK_DEPTH-1:0] rom_stk;
  logic [STACK_DEPTH-1:0] rom_next;
  result_t                res_next;
  result_t                res;
  logic                   in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  pmmu_decode #(
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BYTES  (PAGE_BYTES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_decode (
    .op         (operation),
    .addr       (address),
    .data       (write_byte),
    .level      (level),
    .io_stk     (io_stk),
    .rom_stk    (rom_stk),
    .pte        (pte),
    .res        (res_next),
    .level_next (level_next),
    .io_next    (io_next),
    .rom_next   (rom_next),
    .pte_next   (pte_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      level     <= '0;
      io_stk    <= STACK_DEPTH'(1);
      rom_stk   <= '0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
        pte[i] <= 8'(i);
      end
    end else begin
      if (in_fire) begin
        out_valid <= 1'b1;
        level     <= level_next;
        io_stk    <= io_next;
        rom_stk   <= rom_next;
        pte       <= pte_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign target           = res.target;
  assign physical_address = res.phys;
  assign read_byte        = res.rd;
  assign data_out         = res.dout;
  assign error_code       = res.err;
  assign io_visible       = res.io_vis;
  assign rom_visible      = res.rom_vis;

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    32'(level) < STACK_DEPTH)
    else $error("stack level out of range");

  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

  a_err_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code == E_OVER || error_code == E_UNDER ||
                  error_code == E_ROMWR || error_code == E_UNKNOWN)
    |-> target == T_NONE)
    else $error("faulting beat has a target");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && (res_next.err == E_OVER || res_next.err == E_UNDER ||
                res_next.err == E_ROMWR || res_next.err == E_UNKNOWN)
    |=> $stable(level) && $stable(io_stk) && $stable(rom_stk))
    else $error("faulting beat changed the stack");

  a_push_level: assert property (@(posedge clk) disable iff (rst)
    in_fire && operation == OP_PUSH && res_next.err == E_NONE
    |=> level == LW'($past(level) + 1'b1) && io_visible && !rom_visible)
    else $error("interrupt entry did not raise the level");

endmodule

`default_nettype wire

[tb/sv/paged_memory_map_unit_top_test.sv]
// Self-checking bench for paged_memory_map_unit_top: a directed table, then random bus beats,
// each predicted by a translation model kept in the bench. Depends on pmmu_pkg and the RTL.
// Both channels idle and stall at random; one long output hold and one drain pause included.
module paged_memory_map_unit_top_test;
  import pmmu_pkg::*;

  localparam int RAND_BEATS = 1000;
  localparam int LONG_HOLD  = 64;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    bit          fixed;
    result_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_READ;
  logic [15:0] address = '0;
  logic [7:0]  write_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  target;
  logic [18:0] physical_address;
  logic [7:0]  read_byte;
  logic [7:0]  data_out;
  logic [2:0]  error_code;
  logic        io_visible;
  logic        rom_visible;

  bit      beat_fixed = 1'b0;
  result_t beat_want = '0;

  // translation shadow state
  logic [7:0]  pte_shadow [PAGE_COUNT_DEF];
  logic        io_en [STACK_DEPTH_DEF];
  logic        rom_en [STACK_DEPTH_DEF];
  int unsigned lvl;

  result_t xlat_due [$];
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  bit tgt_seen [16];
  bit err_seen [8];

  bit tx_gaps = 1'b1;
  bit rx_stall = 1'b1;
  bit rx_long = 1'b0;
  bit long_done = 1'b0;

  dir_row_t dir_tab [27] = '{
    '{OP_READ,  16'h0000,  8'h00, 1, '{T_RAM, 19'h0, 8'h00, 8'h00, E_NONE, 1'b1, 1'b0}},
    '{OP_READ,  16'hffff,  8'h00, 1, '{T_ROM, 19'h07fff, 8'h00, 8'h00, E_NONE, 1'b1, 1'b0}},
    '{OP_WRITE, 16'hff00,  8'ha5, 1, '{T_NONE, 19'h0, 8'h00, 8'h00, E_ROMWR, 1'b1, 1'b0}},
    '{OP_READ,  A_KBD,     8'h00, 1, '{T_KBD, 19'h0, 8'h00, 8'h00, E_NONE, 1'b1, 1'b0}},
    '{OP_READ,  A_USB_RD,  8'h00, 1, '{T_USB_RD, 19'h0, 8'h00, 8'h00, E_NONE, 1'b1, 1'b0}},
    '{OP_READ,  16'hfe77,  8'h00, 1, '{T_PTE, 19'h0, 8'h07, 8'h00, E_NONE, 1'b1, 1'b0}},
    '{OP_READ,  16'hfe78,  8'h00, 1, '{T_NONE, 19'h0, 8'h00, 8'h00, E_UNKNOWN, 1'b1, 1'b0}},
    '{OP_WRITE, A_UART,    8'hff, 1, '{T_UART, 19'h0, 8'h00, 8'hff, E_NONE, 1'b1, 1'b0}},
    '{OP_WRITE, A_USB_WR,  8'h00, 0, '0},
    '{OP_WRITE, A_USB_CMD, 8'h5a, 0, '0},
    '{OP_WRITE, 16'hfe99,  8'h3c, 1, '{T_NONE, 19'h0, 8'h00, 8'h00, E_UNKNOWN, 1'b1, 1'b0}},
    '{OP_WRITE, A_POP,     8'h00, 1, '{T_NONE, 19'h0, 8'h00, 8'h00, E_UNDER, 1'b1, 1'b0}},
    '{OP_WRITE, 16'hfe73,  8'hbf, 1, '{T_INTERNAL, 19'h0, 8'h00, 8'h00, E_NONE, 1'b1, 1'b0}},
    '{OP_READ,  16'h7fff,  8'h00, 1, '{T_RAM, 19'h7ffff, 8'h00, 8'h00, E_INVALID, 1'b1, 1'b0}},
    '{OP_WRITE, 16'h6000,  8'h11, 0, '0},
    '{OP_WRITE, A_ROM_ON,  8'h00, 1, '{T_INTERNAL, 19'h0, 8'h00, 8'h00, E_NONE, 1'b1, 1'b1}},
    '{OP_READ,  16'h8000,  8'h00, 1, '{T_ROM, 19'h0, 8'h00, 8'h00, E_NONE, 1'b1, 1'b1}},
    '{OP_LOAD,  16'h8123,  8'h77, 0, '0},
    '{OP_LOAD,  16'h2000,  8'hee, 0, '0},
    '{OP_PUSH,  16'h0000,  8'h00, 0, '0},
    '{OP_PUSH,  16'h1234,  8'h00, 0, '0},
    '{OP_PUSH,  16'hffff,  8'hff, 0, '0},
    '{OP_PUSH,  16'h0000,  8'h00, 1, '{T_NONE, 19'h0, 8'h00, 8'h00, E_OVER, 1'b1, 1'b0}},
    '{OP_WRITE, A_POP,     8'h00, 0, '0},
    '{OP_WRITE, A_USER,    8'h00, 1, '{T_INTERNAL, 19'h0, 8'h00, 8'h00, E_NONE, 1'b0, 1'b0}},
    '{OP_READ,  A_KBD,     8'h00, 0, '0},
    '{OP_PUSH,  16'h0000,  8'h00, 0, '0}
  };

  paged_memory_map_unit_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .address(address), .write_byte(write_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .target(target), .physical_address(physical_address), .read_byte(read_byte),
    .data_out(data_out), .error_code(error_code),
    .io_visible(io_visible), .rom_visible(rom_visible)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [18:0] ram_phys(input logic [15:0] a);
    int unsigned frame;
    frame = pte_shadow[(a / PAGE_BYTES_DEF) % PAGE_COUNT_DEF] % FRAME_COUNT_DEF;
    return 19'((frame * PAGE_BYTES_DEF + a % PAGE_BYTES_DEF) % 524288);
  endfunction

  function automatic bit in_pte_win(input logic [15:0] a);
    return a >= A_PTE && a < A_PTE + PAGE_COUNT_DEF;
  endfunction

  function automatic result_t translate_beat(input logic [1:0] op, input logic [15:0] a,
                                             input logic [7:0] d);
    result_t r;
    int unsigned lv;
    r = '0;
    r.target = T_NONE;
    r.err = E_NONE;
    lv = lvl;
    if (op == OP_PUSH) begin
      if (lv + 1 >= STACK_DEPTH_DEF) begin
        r.err = E_OVER;
      end else begin
        lvl = lv + 1;
        io_en[lvl] = 1'b1;
        rom_en[lvl] = 1'b0;
        r.target = T_INTERNAL;
      end
    end else if (op == OP_LOAD) begin
      r.dout = d;
      if (a >= A_UROM) begin
        r.target = T_ROM;
        r.phys = 19'(a & A_ROM_MASK);
      end else begin
        r.target = T_RAM;
        r.phys = ram_phys(a);
      end
    end else if (a >= A_TOP) begin
      if (op == OP_READ) begin
        r.target = T_ROM;
        r.phys = 19'(a & A_ROM_MASK);
      end else begin
        r.err = E_ROMWR;
      end
    end else if (io_en[lv] && a >= A_IO) begin
      if (op == OP_READ) begin
        if (a == A_KBD) r.target = T_KBD;
        else if (a == A_USB_RD) r.target = T_USB_RD;
        else if (in_pte_win(a)) begin
          r.target = T_PTE;
          r.rd = pte_shadow[(a - A_PTE) % PAGE_COUNT_DEF];
        end else r.err = E_UNKNOWN;
      end else begin
        r.target = T_INTERNAL;
        if (a == A_UART) begin
          r.target = T_UART;
          r.dout = d;
        end else if (a == A_USB_WR) begin
          r.target = T_USB_WR;
          r.dout = d;
        end else if (a == A_USB_CMD) begin
          r.target = T_USB_CMD;
          r.dout = d;
        end else if (a == A_ROM_OFF) begin
          rom_en[lv] = 1'b0;
        end else if (a == A_ROM_ON) begin
          rom_en[lv] = 1'b1;
        end else if (a == A_USER) begin
          lvl = 0;
          io_en[0] = 1'b0;
          rom_en[0] = 1'b0;
        end else if (in_pte_win(a)) begin
          pte_shadow[(a - A_PTE) % PAGE_COUNT_DEF] = d;
        end else if (a == A_POP) begin
          if (lv == 0) begin
            r.target = T_NONE;
            r.err = E_UNDER;
          end else begin
            lvl = lv - 1;
          end
        end else begin
          r.target = T_NONE;
          r.err = E_UNKNOWN;
        end
      end
    end else if (rom_en[lv] && a >= A_UROM) begin
      if (op == OP_READ) begin
        r.target = T_ROM;
        r.phys = 19'(a & A_ROM_MASK);
      end else begin
        r.err = E_ROMWR;
      end
    end else begin
      r.target = T_RAM;
      r.phys = ram_phys(a);
      if (op == OP_WRITE) r.dout = d;
      if ((pte_shadow[(a / PAGE_BYTES_DEF) % PAGE_COUNT_DEF] & PTE_INVALID) != 0)
        r.err = E_INVALID;
    end
    r.io_vis = io_en[lvl];
    r.rom_vis = rom_en[lvl];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // scoreboard: predict on input beats, compare on output beats
  always @(posedge clk) begin
    result_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (xlat_due.size() == 0) begin
          $error("result beat with nothing expected: target %0h", target);
          n_errors++;
        end else begin
          w = xlat_due.pop_front();
          check_field("target", 32'(w.target), 32'(target));
          check_field("physical_address", 32'(w.phys), 32'(physical_address));
          check_field("read_byte", 32'(w.rd), 32'(read_byte));
          check_field("data_out", 32'(w.dout), 32'(data_out));
          check_field("error_code", 32'(w.err), 32'(error_code));
          check_field("io_visible", 32'(w.io_vis), 32'(io_visible));
          check_field("rom_visible", 32'(w.rom_vis), 32'(rom_visible));
          tgt_seen[w.target] = 1'b1;
          err_seen[w.err] = 1'b1;
        end
        n_results++;
      end
      if (in_valid && in_ready) begin
        w = translate_beat(operation, address, write_byte);
        if (beat_fixed) w = beat_want;
        xlat_due.push_back(w);
        n_accepted++;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_long && !long_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        long_done = 1'b1;
      end else if (rx_stall && $urandom_range(5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic drive_beat(input logic [1:0] op, input logic [15:0] a, input logic [7:0] d,
                            input bit fixed, input result_t want);
    if (tx_gaps && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= a;
    write_byte <= d;
    beat_fixed <= fixed;
    beat_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (n_results == n_accepted);
  endtask

  task automatic pick_random(output logic [1:0] op, output logic [15:0] a,
                             output logic [7:0] d);
    logic [15:0] io_regs [7];
    io_regs = '{A_KBD, A_USB_RD, A_UART, A_USB_WR, A_USB_CMD, A_ROM_OFF, A_ROM_ON};
    d = 8'($urandom_range(255));
    op = 2'($urandom_range(1));
    a = 16'($urandom_range(16'hffff));
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: ;
      6, 7, 8, 9: begin
        if ($urandom_range(1)) a = io_regs[$urandom_range(6)];
        else a = A_IO | 16'($urandom_range(255));
      end
      10, 11: begin
        op = OP_WRITE;
        a = A_PTE + 16'($urandom_range(PAGE_COUNT_DEF - 1));
      end
      12: begin
        op = OP_READ;
        a = A_PTE + 16'($urandom_range(PAGE_COUNT_DEF - 1));
      end
      13, 14: op = OP_PUSH;
      15: begin
        op = OP_WRITE;
        a = A_POP;
      end
      16: begin
        op = OP_WRITE;
        a = A_USER;
      end
      17: op = OP_LOAD;
      18: a = 16'($urandom_range(16'hffff, A_TOP));
      default: op = 2'($urandom_range(3));
    endcase
  endtask

  initial begin
    logic [1:0]  op;
    logic [15:0] a;
    logic [7:0]  d;
    int          n_tgt;
    int          n_err;
    for (int i = 0; i < PAGE_COUNT_DEF; i++) pte_shadow[i] = 8'(i);
    for (int i = 0; i < STACK_DEPTH_DEF; i++) begin
      io_en[i] = (i == 0);
      rom_en[i] = 1'b0;
    end
    lvl = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      drive_beat(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].wdata, dir_tab[i].fixed,
                 dir_tab[i].want);

    for (int i = 0; i < RAND_BEATS; i++) begin
      if (i == 300) drain();
      if (i == 400) begin
        tx_gaps = 1'b0;
        rx_long = 1'b1;
      end
      if (i == 460) tx_gaps = 1'b1;
      if (i == RAND_BEATS - 150) begin
        tx_gaps = 1'b0;
        rx_stall = 1'b0;
      end
      pick_random(op, a, d);
      drive_beat(op, a, d, 1'b0, '0);
    end

    drain();
    repeat (4) @(posedge clk);
    n_tgt = 0;
    n_err = 0;
    foreach (tgt_seen[i]) n_tgt += tgt_seen[i];
    foreach (err_seen[i]) n_err += err_seen[i];
    $display("summary: %0d beats in, %0d results compared, %0d mismatches",
             n_accepted, n_results, n_errors);
    $display("summary: %0d distinct targets and %0d distinct error codes exercised",
             n_tgt, n_err);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
